// File: hdl/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

  localparam int DEFAULT_MAX_DIM   = 16;
  localparam int DEFAULT_MAX_BATCH = 4;

  localparam int DIM_CFG_W   = 5;
  localparam int BATCH_CFG_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;
  localparam int CMP_W       = 8;

  localparam logic [1:0] OP_WRITE_LEFT  = 2'd0;
  localparam logic [1:0] OP_WRITE_RIGHT = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BATCHES       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_BATCHED  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_BATCHED = 3'd5;

  localparam logic [DIM_CFG_W-1:0]   ROWS_RESET    = 5'd16;
  localparam logic [DIM_CFG_W-1:0]   INNER_RESET   = 5'd16;
  localparam logic [DIM_CFG_W-1:0]   COLS_RESET    = 5'd16;
  localparam logic [BATCH_CFG_W-1:0] BATCHES_RESET = 3'd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         batch_index;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/batched_matrix_multiply_core.sv
`default_nettype none

// Batched Q16.16 matrix multiply with batch broadcast. Write beats load one element of the
// left or right operand memory and do not stall the input. A read beat computes one result
// element. With its indices in range it runs through the inner count, capped at MAX_DIM,
// and then the final state; a read out of range goes straight to the final state, which
// holds while a waiting result is stalled. The sequencer streams one operand pair per
// cycle out of the left and right memories, then a registered 32x32 multiplier and a 69-bit
// accumulator finish the sum, and the final state truncates and saturates it. Only
// one beat is in flight at a time, so the input stalls until the result has been loaded into
// the output register. Operand memories are not cleared at reset.
module batched_matrix_multiply_core #(
  parameter int MAX_DIM   = bmm_pkg::DEFAULT_MAX_DIM,
  parameter int MAX_BATCH = bmm_pkg::DEFAULT_MAX_BATCH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire bmm_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output bmm_pkg::out_item_t                 out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [bmm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [bmm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_BATCH * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CALC_W = ADDR_W + 8;
  localparam int ACC_W  = 64 + bmm_pkg::DIM_CFG_W;
  localparam int SUM_W  = ACC_W - 16;
  localparam int DW     = bmm_pkg::DIM_CFG_W;
  localparam int CW     = bmm_pkg::CMP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] b,
                                                   input logic [DW-1:0] r,
                                                   input logic [DW-1:0] c);
    logic [CALC_W-1:0] t;
    t = (CALC_W'(b) * CALC_W'(MAX_DIM) + CALC_W'(r)) * CALC_W'(MAX_DIM) + CALC_W'(c);
    return t[ADDR_W-1:0];
  endfunction

  logic [DW-1:0]                   rows_used;
  logic [DW-1:0]                   inner_used;
  logic [DW-1:0]                   cols_used;
  logic [bmm_pkg::BATCH_CFG_W-1:0] batches_used;
  logic                            left_batched;
  logic                            right_batched;

  logic [1:0]              state;
  logic [1:0]              bl;
  logic [1:0]              br;
  logic [3:0]              row;
  logic [3:0]              col;
  logic [DW-1:0]           j;
  logic [DW-1:0]           nj;
  logic                    range_err;
  logic                    data_v;
  logic                    prod_v;
  logic signed [31:0]      left_rd;
  logic signed [31:0]      right_rd;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;

  logic [31:0] left_mem  [DEPTH];
  logic [31:0] right_mem [DEPTH];

  logic              in_accept;
  logic              wr_in_range;
  logic              rd_in_range;
  logic              left_we;
  logic              right_we;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] left_addr;
  logic [ADDR_W-1:0] right_addr;
  logic [DW-1:0]     nj_cfg;
  logic [SUM_W-1:0]  sum;
  logic              sum_ovf;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign wr_in_range = (CW'(in_data.batch_index) < CW'(MAX_BATCH))
                    && (CW'(in_data.row_index) < CW'(MAX_DIM))
                    && (CW'(in_data.col_index) < CW'(MAX_DIM));
  assign rd_in_range = (CW'(in_data.batch_index) < CW'(batches_used))
                    && (CW'(in_data.batch_index) < CW'(MAX_BATCH))
                    && (CW'(in_data.row_index) < CW'(rows_used))
                    && (CW'(in_data.row_index) < CW'(MAX_DIM))
                    && (CW'(in_data.col_index) < CW'(cols_used))
                    && (CW'(in_data.col_index) < CW'(MAX_DIM));
  assign nj_cfg = (CW'(inner_used) > CW'(MAX_DIM)) ? DW'(MAX_DIM) : inner_used;

  assign left_we  = in_accept && wr_in_range && (in_data.opcode == bmm_pkg::OP_WRITE_LEFT);
  assign right_we = in_accept && wr_in_range && (in_data.opcode == bmm_pkg::OP_WRITE_RIGHT);
  assign wr_addr  = store_addr(in_data.batch_index, DW'(in_data.row_index),
                               DW'(in_data.col_index));

  assign rd_en      = (state == ST_RUN) && (j < nj);
  assign left_addr  = store_addr(bl, DW'(row), j);
  assign right_addr = store_addr(br, j, DW'(col));

  assign sum     = acc[ACC_W-1:16];
  assign sum_ovf = !((&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]));

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[wr_addr] <= in_data.value;
    end
    if (rd_en) begin
      left_rd <= left_mem[left_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[wr_addr] <= in_data.value;
    end
    if (rd_en) begin
      right_rd <= right_mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used     <= bmm_pkg::ROWS_RESET;
      inner_used    <= bmm_pkg::INNER_RESET;
      cols_used     <= bmm_pkg::COLS_RESET;
      batches_used  <= bmm_pkg::BATCHES_RESET;
      left_batched  <= 1'b0;
      right_batched <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmm_pkg::REG_ROWS:          rows_used     <= cfg_data;
        bmm_pkg::REG_INNER:         inner_used    <= cfg_data;
        bmm_pkg::REG_COLS:          cols_used     <= cfg_data;
        bmm_pkg::REG_BATCHES:       batches_used  <= cfg_data[bmm_pkg::BATCH_CFG_W-1:0];
        bmm_pkg::REG_LEFT_BATCHED:  left_batched  <= cfg_data[0];
        bmm_pkg::REG_RIGHT_BATCHED: right_batched <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= left_rd * right_rd;
    if (in_accept) begin
      bl        <= left_batched ? in_data.batch_index : 2'd0;
      br        <= right_batched ? in_data.batch_index : 2'd0;
      row       <= in_data.row_index;
      col       <= in_data.col_index;
      nj        <= nj_cfg;
      j         <= '0;
      acc       <= '0;
      range_err <= !rd_in_range;
    end else begin
      if (rd_en) begin
        j <= j + DW'(1);
      end
      if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      data_v    <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      data_v <= rd_en;
      prod_v <= data_v;
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (in_data.opcode == bmm_pkg::OP_READ)) begin
            state <= rd_in_range ? ST_RUN : ST_FIN;
          end
        end
        ST_RUN: begin
          if (!rd_en && !data_v && !prod_v) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (range_err) begin
              out_data.result_value <= '0;
              out_data.status       <= bmm_pkg::STATUS_RANGE;
            end else if (sum_ovf) begin
              out_data.result_value <= sum[SUM_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
              out_data.status       <= bmm_pkg::STATUS_SAT;
            end else begin
              out_data.result_value <= sum[31:0];
              out_data.status       <= bmm_pkg::STATUS_OK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    (left_we || right_we) |-> (state == ST_IDLE))
    else $error("operand write outside idle");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == bmm_pkg::STATUS_RANGE)) |-> (out_data.result_value == 0))
    else $error("out-of-range result is not zero");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j <= nj))
    else $error("inner counter ran past inner count");

  a_fin_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (!data_v && !prod_v))
    else $error("result taken before accumulation drained");

endmodule

`default_nettype wire

// File: tb/sv/tb_batched_matrix_multiply_core.sv
`default_nettype none

module tb_batched_matrix_multiply_core;

  localparam int STORE_DEPTH = bmm_pkg::DEFAULT_MAX_BATCH * bmm_pkg::DEFAULT_MAX_DIM *
                               bmm_pkg::DEFAULT_MAX_DIM;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [bmm_pkg::CFG_INDEX_W-1:0] REG_NONE = 3'd7;
  localparam logic signed [71:0] SUM_MAX = 72'sh7FFFFFFF;
  localparam logic signed [71:0] SUM_MIN = -72'sh80000000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bmm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bmm_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bmm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  batched_matrix_multiply_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Operand copies used to predict products, and the generator's record of written entries.
  logic [31:0] left_mem [0:STORE_DEPTH-1];
  logic [31:0] right_mem [0:STORE_DEPTH-1];
  bit left_set [0:STORE_DEPTH-1];
  bit right_set [0:STORE_DEPTH-1];

  bit left_batched_cfg = 1'b0;
  bit right_batched_cfg = 1'b0;
  int eff_rows = 16;
  int eff_inner = 16;
  int eff_cols = 16;
  int eff_batches = 1;

  bmm_pkg::in_item_t pending_items[$];
  bmm_pkg::out_item_t expected_products[$];
  int items_queued = 0;
  int items_accepted = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bmm_pkg::out_item_t product_element(bmm_pkg::in_item_t rd);
    bmm_pkg::out_item_t res;
    logic signed [31:0] a;
    logic signed [31:0] d;
    logic signed [71:0] acc;
    logic signed [71:0] total;
    logic [1:0] bl;
    logic [1:0] br;
    logic [4:0] j;
    res.result_value = '0;
    res.status = bmm_pkg::STATUS_OK;
    if (rd.batch_index >= eff_batches || rd.row_index >= eff_rows ||
        rd.col_index >= eff_cols) begin
      res.status = bmm_pkg::STATUS_RANGE;
      return res;
    end
    bl = left_batched_cfg ? rd.batch_index : 2'd0;
    br = right_batched_cfg ? rd.batch_index : 2'd0;
    acc = '0;
    for (j = 0; j < eff_inner; j++) begin
      a = left_mem[{bl, rd.row_index, j[3:0]}];
      d = right_mem[{br, j[3:0], rd.col_index}];
      acc = acc + a * d;
    end
    total = acc >>> 16;
    if (total > SUM_MAX) begin
      res.result_value = 32'h7FFFFFFF;
      res.status = bmm_pkg::STATUS_SAT;
    end else if (total < SUM_MIN) begin
      res.result_value = 32'h80000000;
      res.status = bmm_pkg::STATUS_SAT;
    end else begin
      res.result_value = total[31:0];
    end
    return res;
  endfunction

  function automatic int pick(int n);
    return int'($urandom_range(0, (n > 0) ? n - 1 : 0));
  endfunction

  function automatic logic [31:0] next_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 32'h80000000;
          1: v = 32'h7FFFFFFF;
          2: v = 32'h00000000;
          3: v = 32'h00000001;
          4: v = 32'hFFFFFFFF;
          5: v = 32'h00010000;
          default: v = 32'hFFFF0000;
        endcase
      end
      1, 2: v = $urandom;
      default: v = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
    endcase
    return v;
  endfunction

  function automatic void queue_item(logic [1:0] op, logic [1:0] b, logic [3:0] r,
                                     logic [3:0] c, logic [31:0] v);
    bmm_pkg::in_item_t it;
    it.opcode = op;
    it.batch_index = b;
    it.row_index = r;
    it.col_index = c;
    it.value = v;
    pending_items.push_back(it);
    items_queued++;
    if (op == bmm_pkg::OP_WRITE_LEFT) begin
      left_set[{b, r, c}] = 1'b1;
    end else if (op == bmm_pkg::OP_WRITE_RIGHT) begin
      right_set[{b, r, c}] = 1'b1;
    end
  endfunction

  // An in-range read first gets writes for any operand entry it would touch unwritten.
  function automatic void queue_read(logic [1:0] b, logic [3:0] r, logic [3:0] c);
    logic [1:0] bl;
    logic [1:0] br;
    logic [4:0] j;
    bl = left_batched_cfg ? b : 2'd0;
    br = right_batched_cfg ? b : 2'd0;
    if (b < eff_batches && r < eff_rows && c < eff_cols) begin
      for (j = 0; j < eff_inner; j++) begin
        if (!left_set[{bl, r, j[3:0]}]) begin
          queue_item(bmm_pkg::OP_WRITE_LEFT, bl, r, j[3:0], next_value());
        end
        if (!right_set[{br, j[3:0], c}]) begin
          queue_item(bmm_pkg::OP_WRITE_RIGHT, br, j[3:0], c, next_value());
        end
      end
    end
    queue_item(bmm_pkg::OP_READ, b, r, c, $urandom);
  endfunction

  task automatic wait_idle();
    while (items_accepted != items_queued || expected_products.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [4:0] rows, logic [4:0] inner, logic [4:0] cols,
                             logic [4:0] batches, logic [4:0] lb, logic [4:0] rb,
                             bit poke_unused);
    logic [4:0] words [0:6];
    int last;
    words[0] = rows;
    words[1] = inner;
    words[2] = cols;
    words[3] = batches;
    words[4] = lb;
    words[5] = rb;
    words[6] = 5'h1F;
    last = poke_unused ? 6 : 5;
    wait_idle();
    for (int k = 0; k <= last; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 6) ? REG_NONE : k[bmm_pkg::CFG_INDEX_W-1:0];
      cfg_data <= words[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    eff_rows = (rows > bmm_pkg::DEFAULT_MAX_DIM) ? bmm_pkg::DEFAULT_MAX_DIM : rows;
    eff_inner = (inner > bmm_pkg::DEFAULT_MAX_DIM) ? bmm_pkg::DEFAULT_MAX_DIM : inner;
    eff_cols = (cols > bmm_pkg::DEFAULT_MAX_DIM) ? bmm_pkg::DEFAULT_MAX_DIM : cols;
    eff_batches = (batches[2:0] > bmm_pkg::DEFAULT_MAX_BATCH) ?
                  bmm_pkg::DEFAULT_MAX_BATCH : batches[2:0];
    left_batched_cfg = lb[0];
    right_batched_cfg = rb[0];
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      case ($urandom_range(0, 19))
        0: queue_item(OP_UNUSED, 2'($urandom), 4'($urandom), 4'($urandom), $urandom);
        1, 2: queue_read(2'($urandom), 4'($urandom), 4'($urandom));
        3, 4, 5, 6, 7, 8, 9: queue_read(2'(pick(eff_batches)), 4'(pick(eff_rows)),
                                        4'(pick(eff_cols)));
        10, 11, 12: queue_item(bmm_pkg::OP_WRITE_LEFT, 2'(pick(eff_batches)),
                               4'(pick(eff_rows)), 4'(pick(eff_inner)), next_value());
        13, 14, 15: queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'(pick(eff_batches)),
                               4'(pick(eff_inner)), 4'(pick(eff_cols)), next_value());
        default: queue_item($urandom_range(0, 1) ? bmm_pkg::OP_WRITE_RIGHT :
                            bmm_pkg::OP_WRITE_LEFT,
                            2'($urandom), 4'($urandom), 4'($urandom), next_value());
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        items_accepted++;
        case (in_data.opcode)
          bmm_pkg::OP_WRITE_LEFT: left_mem[{in_data.batch_index, in_data.row_index,
                                            in_data.col_index}] = in_data.value;
          bmm_pkg::OP_WRITE_RIGHT: right_mem[{in_data.batch_index, in_data.row_index,
                                              in_data.col_index}] = in_data.value;
          bmm_pkg::OP_READ: expected_products.push_back(product_element(in_data));
          default: ;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 4) - 1;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    bmm_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: value %h status %0d",
                     out_data.result_value, out_data.status);
          end
        end else begin
          want = expected_products.pop_front();
          if (out_data.result_value !== want.result_value ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                       want.result_value, want.status, out_data.result_value,
                       out_data.status);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_batched_matrix_multiply_core: FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_config(5'd4, 5'd2, 5'd4, 5'd2, 5'd1, 5'd0, 1'b1);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd0, 4'd0, 4'd0, 32'h7FFFFFFF);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd0, 4'd0, 4'd1, 32'h7FFFFFFF);
    queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'd0, 4'd0, 4'd0, 32'h7FFFFFFF);
    queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'd0, 4'd1, 4'd0, 32'h7FFFFFFF);
    queue_read(2'd0, 4'd0, 4'd0);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd1, 4'd1, 4'd0, 32'h80000000);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd1, 4'd1, 4'd1, 32'h80000000);
    queue_read(2'd1, 4'd1, 4'd0);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd1, 4'd2, 4'd0, 32'h00000001);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd1, 4'd2, 4'd1, 32'h00000001);
    queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'd0, 4'd0, 4'd3, 32'hFFFFFFFF);
    queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'd0, 4'd1, 4'd3, 32'hFFFFFFFF);
    queue_read(2'd1, 4'd2, 4'd3);
    queue_read(2'd3, 4'd0, 4'd0);
    queue_read(2'd0, 4'd15, 4'd0);
    queue_read(2'd0, 4'd0, 4'd15);
    queue_item(OP_UNUSED, 2'd3, 4'd15, 4'd15, 32'hFFFFFFFF);
    queue_item(bmm_pkg::OP_WRITE_LEFT, 2'd3, 4'd15, 4'd15, 32'h80000000);
    queue_item(bmm_pkg::OP_WRITE_RIGHT, 2'd3, 4'd15, 4'd15, 32'h00000000);
    queue_read(2'd0, 4'd3, 4'd3);

    load_config(5'd16, 5'd16, 5'd16, 5'd1, 5'd0, 5'd0, 1'b0);
    random_phase(110);
    load_config(5'd1, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0, 1'b0);
    random_phase(100);
    load_config(5'd8, 5'd5, 5'd6, 5'd4, 5'd1, 5'd1, 1'b0);
    random_phase(140);
    load_config(5'd31, 5'd31, 5'd31, 5'd7, 5'd2, 5'd3, 1'b0);
    random_phase(150);
    load_config(5'd0, 5'd3, 5'd5, 5'd2, 5'd1, 5'd1, 1'b0);
    random_phase(40);
    load_config(5'd5, 5'd0, 5'd7, 5'd3, 5'd0, 5'd1, 1'b0);
    random_phase(60);
    load_config(5'd9, 5'd6, 5'd3, 5'd0, 5'd1, 5'd0, 1'b0);
    random_phase(40);
    load_config(5'd3, 5'd2, 5'd0, 5'd2, 5'd0, 5'd0, 1'b0);
    random_phase(40);
    repeat (2) begin
      load_config(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                  5'($urandom_range(1, 16)), 5'($urandom_range(1, 4)),
                  5'($urandom_range(0, 1)), 5'($urandom_range(0, 1)), 1'b0);
      random_phase(100);
    end
    load_config(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                5'($urandom_range(1, 16)), 5'($urandom_range(1, 4)),
                5'($urandom_range(0, 1)), 5'($urandom_range(0, 1)), 1'b0);
    quiet = 1'b1;
    random_phase(110);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_batched_matrix_multiply_core: PASS");
    end else begin
      $display("tb_batched_matrix_multiply_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
